/* hdl/sdcr_pkg.sv */
// Shared constants, font table and the stage word for the scaled digit clock renderer.
// Depends on nothing; imported by all modules of the block.
package sdcr_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int GLYPH_SCALE    = 8;
  localparam int TIME_TOP_ROW   = 24;
  localparam int COLON_X        = 62;
  localparam int PAGE_ROWS      = 8;

  localparam logic [7:0] DIGIT_X [4] = '{8'd7, 8'd34, 8'd74, 8'd101};

  // floor(n/1000) = (n*RECIP_1000) >> 38 for any 32-bit n
  localparam logic [31:0] RECIP_1000 = 32'd274877907;
  localparam int          SHIFT_1000 = 38;
  // floor(n/60) for n < 2^23
  localparam logic [23:0] RECIP_60   = 24'd8947849;
  localparam int          SHIFT_60   = 29;
  // floor(n/100) for n < 2^17
  localparam logic [17:0] RECIP_100  = 18'd167773;
  localparam int          SHIFT_100  = 24;

  // rows top to bottom, bit 2 is the leftmost cell
  localparam logic [2:0] FONT [10][5] = '{
    '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
    '{3'h2, 3'h6, 3'h2, 3'h2, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
    '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
    '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
    '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
    '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h1, 3'h2, 3'h2, 3'h2},
    '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
    '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7}
  };

  typedef struct packed {
    logic       valid;
    logic [2:0] page;
    logic [6:0] column;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
  } sdcr_digits_t;

  function automatic logic [2:0] font_row(input logic [3:0] digit, input logic [2:0] row);
    logic [2:0] bits;
    bits = 3'b000;
    if (digit <= 4'd9 && row <= 3'd4) begin
      bits = FONT[digit][row];
    end
    return bits;
  endfunction

endpackage

/* hdl/sdcr_time_split.sv */
// Four-stage split of elapsed milliseconds into MM:SS decimal digits.
// Reciprocal multiplies divide by 1000, 60 and 100, then a tens and ones split; depends on sdcr_pkg.
module sdcr_time_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          mission_ms,
  input  logic [2:0]           page,
  input  logic [6:0]           column,
  output sdcr_pkg::sdcr_digits_t digits
);
  import sdcr_pkg::*;

  function automatic logic [7:0] split_dec(input logic [6:0] x);
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  ones;
    t    = 15'(x) * 15'd205;
    tens = t[14:11];
    ones = x - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  // stage 1
  logic        v1;
  logic [2:0]  pg1;
  logic [6:0]  col1;
  logic [63:0] prod1;
  // stage 2
  logic        v2;
  logic [2:0]  pg2;
  logic [6:0]  col2;
  logic [22:0] secs2;
  logic [46:0] prod2;
  // stage 3
  logic        v3;
  logic [2:0]  pg3;
  logic [6:0]  col3;
  logic [16:0] mins3;
  logic [5:0]  sec3;
  logic [34:0] prod3;

  logic [22:0] secs1;
  logic [16:0] mins2;
  logic [22:0] rem2;
  logic [9:0]  hund3;
  logic [6:0]  mmod3;
  logic [7:0]  mdec;
  logic [7:0]  sdec;

  assign secs1 = prod1[SHIFT_1000 + 22:SHIFT_1000];
  assign mins2 = prod2[SHIFT_60 + 16:SHIFT_60];
  assign rem2  = secs2 - 23'(mins2) * 23'd60;
  assign hund3 = prod3[SHIFT_100 + 9:SHIFT_100];
  assign mmod3 = 7'(mins3 - 17'(hund3) * 17'd100);
  assign mdec  = split_dec(mmod3);
  assign sdec  = split_dec({1'b0, sec3});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      digits.valid <= 1'b0;
    end else begin
      v1           <= start;
      v2           <= v1;
      v3           <= v2;
      digits.valid <= v3;
    end
    pg1   <= page;
    col1  <= column;
    prod1 <= 64'(mission_ms) * 64'(RECIP_1000);

    pg2   <= pg1;
    col2  <= col1;
    secs2 <= secs1;
    prod2 <= 47'(secs1) * 47'(RECIP_60);

    pg3   <= pg2;
    col3  <= col2;
    mins3 <= mins2;
    sec3  <= rem2[5:0];
    prod3 <= 35'(mins2) * 35'(RECIP_100);

    digits.page     <= pg3;
    digits.column   <= col3;
    digits.min_tens <= mdec[7:4];
    digits.min_ones <= mdec[3:0];
    digits.sec_tens <= sdec[7:4];
    digits.sec_ones <= sdec[3:0];
  end

endmodule

/* hdl/sdcr_render.sv */
// Final stage: lights the eight pixels of one page byte from the four digits and colon.
// Depends on sdcr_pkg for layout, font and the digit word.
module sdcr_render (
  input  logic                   clk,
  input  logic                   rst,
  input  sdcr_pkg::sdcr_digits_t digits,
  output logic                   done,
  output logic [7:0]             pixel_byte
);
  import sdcr_pkg::*;

  logic [7:0] byte_next;

  always_comb begin
    logic [8:0] px;
    logic [8:0] py;
    logic [8:0] dx;
    logic [8:0] dy;
    logic [8:0] cx;
    logic [8:0] cy;
    logic [3:0] dig [4];
    logic [2:0] row_bits;
    logic       lit;
    dx       = '0;
    dy       = '0;
    cx       = '0;
    cy       = '0;
    row_bits = '0;
    dig[0] = digits.min_tens;
    dig[1] = digits.min_ones;
    dig[2] = digits.sec_tens;
    dig[3] = digits.sec_ones;
    px = 9'(digits.column);
    byte_next = 8'h00;
    for (int n = 0; n < 8; n++) begin
      py  = 9'(digits.page) * 9'(PAGE_ROWS) + 9'(n);
      lit = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (px >= 9'(DIGIT_X[k]) && py >= 9'(TIME_TOP_ROW)) begin
          dx = px - 9'(DIGIT_X[k]);
          dy = py - 9'(TIME_TOP_ROW);
          cx = dx / 9'(GLYPH_SCALE);
          cy = dy / 9'(GLYPH_SCALE);
          if (cx < 9'd3 && cy < 9'd5) begin
            row_bits = font_row(dig[k], cy[2:0]);
            if (row_bits[2'(9'd2 - cx)]) begin
              lit = 1'b1;
            end
          end
        end
      end
      if (px >= 9'(COLON_X) && px < 9'(COLON_X + GLYPH_SCALE)) begin
        if ((py >= 9'(TIME_TOP_ROW + GLYPH_SCALE) && py < 9'(TIME_TOP_ROW + 2 * GLYPH_SCALE))
            || (py >= 9'(TIME_TOP_ROW + 3 * GLYPH_SCALE)
                && py < 9'(TIME_TOP_ROW + 4 * GLYPH_SCALE))) begin
          lit = 1'b1;
        end
      end
      if (px >= 9'(DISPLAY_WIDTH) || py >= 9'(DISPLAY_HEIGHT)) begin
        lit = 1'b0;
      end
      byte_next[n] = lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= digits.valid;
    end
    pixel_byte <= byte_next;
  end

endmodule

/* hdl/scaled_digit_clock_renderer_top.sv */
// Scaled digit clock renderer: one framebuffer byte of an MM:SS picture per word.
// One word accepted every cycle; done follows start through the pipeline below.
// Four time-split stages (reciprocal multiplies) and one render stage make it up.
// busy is always low; the result strobe cannot be held off.
// Synchronous reset clears the pipeline valid bits; no other state.
// Depends on sdcr_pkg, sdcr_time_split and sdcr_render.
module scaled_digit_clock_renderer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] mission_ms,
  input  logic [2:0]  page,
  input  logic [6:0]  column,
  output logic        done,
  output logic [7:0]  pixel_byte
);
  import sdcr_pkg::*;

  sdcr_digits_t digits;

  assign busy = 1'b0;

  sdcr_time_split u_split (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mission_ms (mission_ms),
    .page       (page),
    .column     (column),
    .digits     (digits)
  );

  sdcr_render u_render (
    .clk        (clk),
    .rst        (rst),
    .digits     (digits),
    .done       (done),
    .pixel_byte (pixel_byte)
  );

endmodule

/* dv/scaled_digit_clock_renderer_top_tb.sv */
// Testbench for scaled_digit_clock_renderer_top: directed and random framebuffer words,
// checked against an independent MM:SS glyph renderer held in a small scoreboard class.
// Depends on sdcr_pkg for display geometry and on the block's RTL.
module scaled_digit_clock_renderer_top_tb;
  import sdcr_pkg::*;

  class pixel_scoreboard;
    typedef struct {
      bit [31:0] ms;
      bit [2:0]  pg;
      bit [6:0]  col;
      bit [7:0]  byte_exp;
    } pixel_word_t;

    pixel_word_t pending_q[$];
    int unsigned mismatches = 0;
    int unsigned digit_col[4] = '{7, 34, 74, 101};

    // 3x5 font, rows top to bottom, leftmost cell is the high bit of each row
    function bit [14:0] glyph_of(int unsigned d);
      case (d)
        0: return 15'b111_101_101_101_111;
        1: return 15'b010_110_010_010_111;
        2: return 15'b111_001_111_100_111;
        3: return 15'b111_001_111_001_111;
        4: return 15'b101_101_111_001_001;
        5: return 15'b111_100_111_001_111;
        6: return 15'b111_100_111_101_111;
        7: return 15'b111_001_010_010_010;
        8: return 15'b111_101_111_101_111;
        9: return 15'b111_101_111_001_111;
        default: return 15'b0;
      endcase
    endfunction

    function bit [7:0] render_byte(bit [31:0] ms, bit [2:0] pg, bit [6:0] col);
      int unsigned tenths, minutes, seconds, px, py, cx, cy, s, top;
      int unsigned dig[4];
      bit [14:0] glyph;
      bit [7:0] res;
      bit lit;
      tenths  = ms / 100;
      minutes = tenths / 600;
      seconds = (tenths / 10) % 60;
      dig[0] = (minutes / 10) % 10;
      dig[1] = minutes % 10;
      dig[2] = seconds / 10;
      dig[3] = seconds % 10;
      s   = GLYPH_SCALE;
      top = TIME_TOP_ROW;
      px  = 32'(col);
      res = '0;
      for (int n = 0; n < 8; n++) begin
        py  = 32'(pg) * 8 + n;
        lit = 1'b0;
        if (px < DISPLAY_WIDTH && py < DISPLAY_HEIGHT) begin
          for (int k = 0; k < 4; k++) begin
            if (px >= digit_col[k] && py >= top) begin
              cx = (px - digit_col[k]) / s;
              cy = (py - top) / s;
              if (cx < 3 && cy < 5) begin
                glyph = glyph_of(dig[k]);
                if (glyph[14 - 3 * cy - cx]) lit = 1'b1;
              end
            end
          end
          if (px >= COLON_X && px < COLON_X + s) begin
            if ((py >= top + s && py < top + 2 * s) ||
                (py >= top + 3 * s && py < top + 4 * s)) lit = 1'b1;
          end
        end
        res[n] = lit;
      end
      return res;
    endfunction

    function void note_word(bit [31:0] ms, bit [2:0] pg, bit [6:0] col);
      pixel_word_t w;
      w.ms       = ms;
      w.pg       = pg;
      w.col      = col;
      w.byte_exp = render_byte(ms, pg, col);
      pending_q.push_back(w);
    endfunction

    function void check_word(bit [7:0] actual);
      pixel_word_t w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word pixel_byte=%02h", actual);
        return;
      end
      w = pending_q.pop_front();
      if (actual !== w.byte_exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: ms=%0d page=%0d column=%0d pixel_byte exp=%02h got=%02h",
                   w.ms, w.pg, w.col, w.byte_exp, actual);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] mission_ms = '0;
  logic [2:0]  page = '0;
  logic [6:0]  column = '0;
  logic        busy;
  logic        done;
  logic [7:0]  pixel_byte;

  pixel_scoreboard frame_sb = new();
  int unsigned words_sent = 0;

  scaled_digit_clock_renderer_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mission_ms(mission_ms),
    .page(page),
    .column(column),
    .done(done),
    .pixel_byte(pixel_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0) frame_sb.note_word(mission_ms, page, column);
      if (done === 1'b1) frame_sb.check_word(pixel_byte);
    end
  end

  task automatic send_word(input bit [31:0] ms, input bit [2:0] pg, input bit [6:0] col);
    start      <= 1'b1;
    mission_ms <= ms;
    page       <= pg;
    column     <= col;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start      <= 1'b0;
      mission_ms <= $urandom;
      page       <= 3'($urandom);
      column     <= 7'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic bit [31:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return $urandom;
    if (sel < 75) return $urandom_range(0, 99) * 60000 + $urandom_range(0, 59999);
    // minutes past 99 wrap
    return $urandom_range(1, 714) * 6000000 + $urandom_range(0, 99) * 60000
           + $urandom_range(0, 59999);
  endfunction

  initial begin
    bit [31:0]   ms;
    bit [2:0]    pg;
    bit [6:0]    col;
    int unsigned burst_len, guard;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(32'd0, 3'd0, 7'd0);
    send_word(32'hFFFF_FFFF, 3'd7, 7'd127);
    send_word(32'd5999999, 3'd3, 7'd7);
    send_word(32'd5999999, 3'd7, 7'd30);
    send_word(32'd6000000, 3'd3, 7'd34);
    send_word(32'd6059999, 3'd4, 7'd101);
    send_word(32'd599999, 3'd5, 7'd74);
    send_word(32'd0, 3'd4, 7'd62);
    send_word(32'd0, 3'd5, 7'd69);
    send_word(32'd0, 3'd6, 7'd65);
    send_word(32'd0, 3'd3, 7'd62);
    send_word(32'd0, 3'd4, 7'd70);
    send_word(32'd0, 3'd4, 7'd61);
    send_word(32'd0, 3'd3, 7'd31);
    send_word(32'd0, 3'd3, 7'd6);
    send_word(32'd1234567, 3'd6, 7'd36);
    send_word(32'd2345678, 3'd5, 7'd46);
    send_word(32'd3456789, 3'd4, 7'd80);
    send_word(32'd4567890, 3'd3, 7'd105);
    send_word(32'd5678901, 3'd7, 7'd118);
    send_word(32'd1799999, 3'd6, 7'd124);
    send_word(32'd60000, 3'd2, 7'd20);
    send_word(32'd99, 3'd4, 7'd125);
    send_word(32'hFFFF_FFFF, 3'd5, 7'd110);
    idle_gap(3);

    while (words_sent < 1525) begin
      ms        = pick_time();
      burst_len = $urandom_range(1, 32);
      if ($urandom_range(0, 3) == 0) begin
        pg  = 3'($urandom);
        col = 7'($urandom);
        for (int i = 0; i < burst_len; i++) begin
          send_word(ms, pg, col);
          col++;
        end
      end else begin
        for (int i = 0; i < burst_len; i++) begin
          pg  = 3'($urandom_range(3, 7));
          col = ($urandom_range(0, 2) == 0) ? 7'($urandom) : 7'($urandom_range(5, 126));
          send_word(ms, pg, col);
        end
      end
      if ($urandom_range(0, 9) < 3) idle_gap(0);
      else idle_gap($urandom_range(1, 8));
    end

    start <= 1'b0;
    guard = 0;
    while (frame_sb.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);

    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("PASS scaled_digit_clock_renderer_top");
    end else begin
      $display("FAIL scaled_digit_clock_renderer_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL scaled_digit_clock_renderer_top");
    $finish;
  end

endmodule

/* sim.f */
hdl/sdcr_pkg.sv
hdl/sdcr_time_split.sv
hdl/sdcr_render.sv
hdl/scaled_digit_clock_renderer_top.sv
dv/scaled_digit_clock_renderer_top_tb.sv
